FILE: design/xsr_pkg.sv
// ----------------------------------------------------------------------------
// xsr_pkg
// Shared types, constants and the xorshift128 step for the random ranger.
// ----------------------------------------------------------------------------
`default_nettype none

package xsr_pkg;

    localparam int unsigned TABLE_DEPTH   = 16;
    localparam int unsigned TABLE_IDX_W   = $clog2(TABLE_DEPTH);
    localparam int unsigned COUNT_W       = 5;
    localparam int unsigned WARMUP_STEPS  = 32;
    localparam logic [31:0] DEFAULT_SEED  = 32'd1;
    localparam logic [31:0] RESET_SEED    = 32'd1;

    localparam logic [31:0] INIT_Y        = 32'd362436069;
    localparam logic [31:0] INIT_Z        = 32'd521288629;
    localparam logic [31:0] INIT_W        = 32'd88675123;
    localparam logic [31:0] DRAW_OFFSET   = 32'h8000_0000;

    localparam int unsigned S_TDATA_W     = 128;
    localparam int unsigned M_TDATA_W     = 40;

    typedef enum logic [1:0] {
        MODE_RANGE  = 2'd0,
        MODE_BOOL   = 2'd1,
        MODE_CHOICE = 2'd2,
        MODE_LOAD   = 2'd3
    } mode_t;

    typedef struct packed {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic [31:0] w;
    } gen_state_t;

    typedef struct packed {
        logic        busy;
        logic [31:0] draw;
    } gen_status_t;

    function automatic gen_state_t xs_advance(input gen_state_t s);
        logic [31:0] t;
        gen_state_t  n;
        t   = s.x ^ (s.x << 11);
        n.x = s.y;
        n.y = s.z;
        n.z = s.w;
        n.w = s.w ^ (s.w >> 19) ^ t ^ (t >> 8);
        return n;
    endfunction

    function automatic gen_state_t xs_seed(input logic [31:0] seed);
        gen_state_t n;
        n.x = seed;
        n.y = INIT_Y;
        n.z = INIT_Z;
        n.w = INIT_W;
        return n;
    endfunction

endpackage

`default_nettype wire

FILE: design/xorshift128_random_ranger.sv
// ----------------------------------------------------------------------------
// xorshift128_random_ranger
// Xorshift128 random source with range, boolean and table-choice draws.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on the s_axis channel (mode in tuser, operands in tdata).
//   Range, boolean and choice requests each return one result on m_axis;
//   load-table requests write one table entry and return nothing.
//   An accepted request is held in the input register; the generator step,
//   the 32x32 multiply and the table read then run in one pass into the
//   output register. While m_axis takes results and no warm-up runs, one
//   request per cycle is sustained; the generator state loop closes in one pass.
//   After reset the generator is seeded with 1 and runs WARMUP_STEPS
//   steps, one per cycle, with s_axis_tready low; a write to the seed
//   register restarts that warm-up. The table resets to all zeros. A
//   stalled m_axis holds its result; one more request is held in the
//   input register, after which s_axis_tready drops. The seed must be
//   written only while no request is in flight; the block does not enforce it.
// ----------------------------------------------------------------------------
`default_nettype none

module xorshift128_random_ranger
    import xsr_pkg::*;
#(
    parameter int unsigned WARMUP_STEPS_P = WARMUP_STEPS,
    parameter logic [31:0] DEFAULT_SEED_P = DEFAULT_SEED
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 seed_wr_en,
    input  wire logic [31:0]          seed_value,
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    // low_bound, high_bound, probability, count, entry_index, entry_value
    input  wire logic [S_TDATA_W-1:0] s_axis_tdata,
    // mode
    input  wire logic [1:0]           s_axis_tuser,
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    // result_value, chosen_index
    output logic [M_TDATA_W-1:0]      m_axis_tdata
);

    // input register
    logic                   s1_valid_reg;
    mode_t                  s1_mode_reg;
    logic signed [31:0]     s1_low_reg;
    logic signed [31:0]     s1_high_reg;
    logic [16:0]            s1_prob_reg;
    logic [COUNT_W-1:0]     s1_count_reg;
    logic [TABLE_IDX_W-1:0] s1_eidx_reg;
    logic [31:0]            s1_eval_reg;

    // output register
    logic                   out_valid_reg;
    logic [31:0]            out_value_reg, out_value_next;
    logic [TABLE_IDX_W-1:0] out_index_reg, out_index_next;

    gen_status_t            gen_status;
    logic                   out_ready;
    logic                   s1_move;
    logic                   s_accept;
    logic                   gen_step;
    logic                   tbl_we;
    logic [31:0]            tbl_rd_data;

    logic [31:0]            lo_sel, hi_sel, span;
    logic [63:0]            range_prod;
    logic [COUNT_W-1:0]     count_sat;
    logic [COUNT_W+31:0]    choice_prod;
    logic [COUNT_W-1:0]     pick_raw, pick;

    assign out_ready     = !out_valid_reg || m_axis_tready;
    assign s1_move       = s1_valid_reg && ((s1_mode_reg == MODE_LOAD) || out_ready);
    assign s_axis_tready = !gen_status.busy && (!s1_valid_reg || s1_move);
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s_accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_move)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            s1_mode_reg  <= mode_t'(s_axis_tuser);
            s1_low_reg   <= s_axis_tdata[31:0];
            s1_high_reg  <= s_axis_tdata[63:32];
            s1_prob_reg  <= s_axis_tdata[80:64];
            s1_count_reg <= s_axis_tdata[85:81];
            s1_eidx_reg  <= s_axis_tdata[89:86];
            s1_eval_reg  <= s_axis_tdata[121:90];
        end
    end

    // range: order the bounds, then scale the span by the draw
    always_comb
    begin
        if (s1_high_reg < s1_low_reg)
        begin
            lo_sel = s1_low_reg;
            hi_sel = s1_low_reg;
            lo_sel = s1_high_reg;
        end
        else
        begin
            lo_sel = s1_low_reg;
            hi_sel = s1_high_reg;
        end
    end

    assign span       = hi_sel - lo_sel;
    assign range_prod = {32'd0, span} * {32'd0, gen_status.draw};

    // choice: saturate the count, scale it by the draw, clamp the pick
    assign count_sat   = (s1_count_reg > COUNT_W'(TABLE_DEPTH)) ?
                         COUNT_W'(TABLE_DEPTH) : s1_count_reg;
    assign choice_prod = {32'd0, count_sat} * {{COUNT_W{1'b0}}, gen_status.draw};
    assign pick_raw    = choice_prod[COUNT_W+31:32];
    assign pick        = (pick_raw >= count_sat) ? (count_sat - COUNT_W'(1)) : pick_raw;

    always_comb
    begin
        gen_step       = 1'b0;
        tbl_we         = 1'b0;
        out_value_next = '0;
        out_index_next = '0;
        case (s1_mode_reg)
            MODE_RANGE:
            begin
                gen_step       = s1_move;
                out_value_next = lo_sel + range_prod[63:32];
            end
            MODE_BOOL:
            begin
                // a probability above one always wins, as the draw stays below it
                gen_step       = s1_move;
                out_value_next = {31'd0, ({1'b0, gen_status.draw[31:16]} < s1_prob_reg)};
            end
            MODE_CHOICE:
            begin
                if (count_sat != '0)
                begin
                    gen_step       = s1_move;
                    out_value_next = tbl_rd_data;
                    out_index_next = pick[TABLE_IDX_W-1:0];
                end
            end
            MODE_LOAD:
            begin
                tbl_we = s1_move;
            end
            default:
            begin
                gen_step = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_move && (s1_mode_reg != MODE_LOAD))
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_move && (s1_mode_reg != MODE_LOAD))
        begin
            out_value_reg <= out_value_next;
            out_index_reg <= out_index_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'd0, out_index_reg, out_value_reg};

    xsr_gen #(
        .WARMUP_STEPS_P (WARMUP_STEPS_P),
        .DEFAULT_SEED_P (DEFAULT_SEED_P)
    ) u_gen (
        .clk        (clk),
        .rst_n      (rst_n),
        .seed_wr_en (seed_wr_en),
        .seed_value (seed_value),
        .step_en    (gen_step),
        .status     (gen_status)
    );

    xsr_table u_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (tbl_we),
        .wr_addr (s1_eidx_reg),
        .wr_data (s1_eval_reg),
        .rd_addr (pick[TABLE_IDX_W-1:0]),
        .rd_data (tbl_rd_data)
    );

`ifndef SYNTH
    a_busy_blocks_requests: assert property (@(posedge clk) disable iff (!rst_n)
        gen_status.busy |-> !s_axis_tready)
        else $error("request taken during generator warm-up");

    a_load_gives_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(s1_valid_reg && (s1_mode_reg != MODE_LOAD)))
        else $error("result appeared without a drawing request");

    a_step_xor_write: assert property (@(posedge clk) disable iff (!rst_n)
        !(tbl_we && gen_step))
        else $error("table write and generator step in the same cycle");
`endif

endmodule

`default_nettype wire

FILE: design/xsr_gen.sv
// ----------------------------------------------------------------------------
// xsr_gen
// Xorshift128 state, seed load and warm-up sequencer; gives the next draw.
// ----------------------------------------------------------------------------
`default_nettype none

module xsr_gen
    import xsr_pkg::*;
#(
    parameter int unsigned WARMUP_STEPS_P = WARMUP_STEPS,
    parameter logic [31:0] DEFAULT_SEED_P = DEFAULT_SEED
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        seed_wr_en,
    input  wire logic [31:0] seed_value,
    input  wire logic        step_en,
    output gen_status_t      status
);

    localparam int unsigned WCNT_W =
        ($clog2(WARMUP_STEPS_P + 1) > 0) ? $clog2(WARMUP_STEPS_P + 1) : 1;

    gen_state_t        state_reg,  state_next;
    logic [WCNT_W-1:0] warm_reg,   warm_next;
    gen_state_t        stepped;

    assign stepped = xs_advance(state_reg);

    always_comb
    begin
        state_next = state_reg;
        warm_next  = warm_reg;
        if (seed_wr_en)
        begin
            // a zero seed is replaced with DEFAULT_SEED_P
            state_next = xs_seed((seed_value == 32'd0) ? DEFAULT_SEED_P : seed_value);
            warm_next  = WCNT_W'(WARMUP_STEPS_P);
        end
        else if (warm_reg != '0)
        begin
            state_next = stepped;
            warm_next  = warm_reg - WCNT_W'(1);
        end
        else if (step_en)
        begin
            state_next = stepped;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= xs_seed(RESET_SEED);
            warm_reg  <= WCNT_W'(WARMUP_STEPS_P);
        end
        else
        begin
            state_reg <= state_next;
            warm_reg  <= warm_next;
        end
    end

    assign status.busy = (warm_reg != '0);
    assign status.draw = stepped.w + DRAW_OFFSET;

endmodule

`default_nettype wire

FILE: design/xsr_table.sv
// ----------------------------------------------------------------------------
// xsr_table
// Choice table: one write port, one read port, cleared by reset.
// ----------------------------------------------------------------------------
`default_nettype none

module xsr_table
    import xsr_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   wr_en,
    input  wire logic [TABLE_IDX_W-1:0] wr_addr,
    input  wire logic [31:0]            wr_data,
    input  wire logic [TABLE_IDX_W-1:0] rd_addr,
    output logic [31:0]                 rd_data
);

    logic [31:0] entry_reg [TABLE_DEPTH];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < TABLE_DEPTH; i++)
            begin
                entry_reg[i] <= '0;
            end
        end
        else if (wr_en)
        begin
            entry_reg[wr_addr] <= wr_data;
        end
    end

    assign rd_data = entry_reg[rd_addr];

endmodule

`default_nettype wire

FILE: dv/xorshift128_random_ranger_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// xorshift128_random_ranger_checker
// Watches the request, result and seed ports of the random ranger, keeps its
// own generator and choice table, and compares every result with the draw
// predicted for the oldest outstanding request.
// ----------------------------------------------------------------------------
module xorshift128_random_ranger_checker
    import xsr_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 seed_wr_en,
    input  logic [31:0]          seed_value,
    input  logic                 s_axis_tvalid,
    input  logic                 s_axis_tready,
    input  logic [S_TDATA_W-1:0] s_axis_tdata,
    input  logic [1:0]           s_axis_tuser,
    input  logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    input  logic [M_TDATA_W-1:0] m_axis_tdata,
    output int unsigned          mismatch_count,
    output int unsigned          pending_draws,
    output int unsigned          checked_draws
);

    localparam int unsigned LO_LSB   = 0;
    localparam int unsigned HI_LSB   = 32;
    localparam int unsigned PROB_LSB = 64;
    localparam int unsigned CNT_LSB  = 81;
    localparam int unsigned IDX_LSB  = 86;
    localparam int unsigned VAL_LSB  = 90;

    typedef struct packed {
        logic [3:0]  pick;
        logic [31:0] value;
    } draw_result_t;

    logic [31:0]  gen_x;
    logic [31:0]  gen_y;
    logic [31:0]  gen_z;
    logic [31:0]  gen_w;
    logic [31:0]  choice_mem [TABLE_DEPTH];
    draw_result_t predicted_draws [$];
    int unsigned  n_mismatch;
    int unsigned  n_checked;

    initial
    begin
        n_mismatch = 0;
        n_checked  = 0;
    end

    task automatic advance_gen(output logic [31:0] draw);
        logic [31:0] t;
        t     = gen_x ^ (gen_x << 11);
        gen_x = gen_y;
        gen_y = gen_z;
        gen_z = gen_w;
        gen_w = gen_w ^ (gen_w >> 19) ^ t ^ (t >> 8);
        draw  = gen_w + DRAW_OFFSET;
    endtask

    task automatic reseed_gen(input logic [31:0] seed);
        logic [31:0] discard;
        gen_x = (seed == 32'd0) ? DEFAULT_SEED : seed;
        gen_y = INIT_Y;
        gen_z = INIT_Z;
        gen_w = INIT_W;
        repeat (WARMUP_STEPS) advance_gen(discard);
    endtask

    task automatic predict_request(input logic [S_TDATA_W-1:0] data, input mode_t mode);
        logic [31:0]  lo;
        logic [31:0]  hi;
        logic [31:0]  swap;
        logic [31:0]  draw;
        logic [31:0]  pick;
        logic [16:0]  prob;
        logic [4:0]   cnt;
        logic [3:0]   slot;
        logic [63:0]  prod;
        draw_result_t res;
        lo   = data[LO_LSB +: 32];
        hi   = data[HI_LSB +: 32];
        prob = data[PROB_LSB +: 17];
        cnt  = data[CNT_LSB +: 5];
        slot = data[IDX_LSB +: 4];
        res  = '0;
        case (mode)
            MODE_LOAD:
            begin
                if (slot < TABLE_DEPTH)
                    choice_mem[slot] = data[VAL_LSB +: 32];
                return;
            end
            MODE_RANGE:
            begin
                if ($signed(hi) < $signed(lo))
                begin
                    swap = lo;
                    lo   = hi;
                    hi   = swap;
                end
                advance_gen(draw);
                prod      = {32'd0, hi - lo} * {32'd0, draw};
                res.value = lo + prod[63:32];
            end
            MODE_BOOL:
            begin
                if (prob > 17'd65536)
                    prob = 17'd65536;
                advance_gen(draw);
                res.value = ({1'b0, draw[31:16]} < prob) ? 32'd1 : 32'd0;
            end
            default:
            begin
                if (cnt > TABLE_DEPTH)
                    cnt = 5'(TABLE_DEPTH);
                // an empty choice leaves the generator alone
                if (cnt != 5'd0)
                begin
                    advance_gen(draw);
                    prod = {59'd0, cnt} * {32'd0, draw};
                    pick = prod[63:32];
                    if (pick >= cnt)
                        pick = cnt - 1;
                    res.pick  = pick[3:0];
                    res.value = choice_mem[pick[3:0]];
                end
            end
        endcase
        predicted_draws.push_back(res);
    endtask

    task automatic flag_mismatch(input string what, input draw_result_t want,
                                 input draw_result_t got);
        n_mismatch++;
        if (n_mismatch <= 10)
            $display("%0t mismatch (%s): expected value %h index %0d, got value %h index %0d",
                     $realtime, what, want.value, want.pick, got.value, got.pick);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        draw_result_t got;
        draw_result_t want;
        if (!rst_n)
        begin
            reseed_gen(RESET_SEED);
            for (int i = 0; i < TABLE_DEPTH; i++)
                choice_mem[i] = 32'd0;
            predicted_draws.delete();
        end
        else
        begin
            // results first, so a request taken at the same edge cannot satisfy one
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.value = m_axis_tdata[31:0];
                got.pick  = m_axis_tdata[35:32];
                if (predicted_draws.size() == 0)
                    flag_mismatch("no request outstanding", '0, got);
                else
                begin
                    want = predicted_draws.pop_front();
                    n_checked++;
                    if (got.value !== want.value || got.pick !== want.pick)
                        flag_mismatch("wrong field", want, got);
                end
            end
            if (seed_wr_en)
                reseed_gen(seed_value);
            if (s_axis_tvalid && s_axis_tready)
                predict_request(s_axis_tdata, mode_t'(s_axis_tuser));
        end
        mismatch_count <= n_mismatch;
        pending_draws  <= predicted_draws.size();
        checked_draws  <= n_checked;
    end

endmodule

FILE: dv/xorshift128_random_ranger_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// xorshift128_random_ranger_tb
// Drives range, boolean, choice and table-load requests into the random
// ranger over several seeds, with random gaps and stalls on both streams, a
// long output hold-off and idle drains; a checker predicts every draw.
// ----------------------------------------------------------------------------
module xorshift128_random_ranger_tb;

    import xsr_pkg::*;

    localparam int unsigned HOLDOFF_CYCLES = 64;

    logic                 clk           = 1'b0;
    logic                 rst_n         = 1'b0;
    logic                 seed_wr_en    = 1'b0;
    logic [31:0]          seed_value    = 32'd0;
    logic                 s_axis_tvalid = 1'b0;
    logic [S_TDATA_W-1:0] s_axis_tdata  = '0;
    logic [1:0]           s_axis_tuser  = 2'd0;
    logic                 m_axis_tready = 1'b0;
    wire                  s_axis_tready;
    wire                  m_axis_tvalid;
    wire  [M_TDATA_W-1:0] m_axis_tdata;

    int unsigned mismatch_count;
    int unsigned pending_draws;
    int unsigned checked_draws;

    bit          sender_steady = 1'b0;
    bit          recv_steady   = 1'b0;
    int unsigned holdoff_asks  = 0;
    int unsigned requests_sent = 0;
    int unsigned seeds_written = 0;

    xorshift128_random_ranger dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .seed_wr_en    (seed_wr_en),
        .seed_value    (seed_value),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    xorshift128_random_ranger_checker checker_i (
        .clk            (clk),
        .rst_n          (rst_n),
        .seed_wr_en     (seed_wr_en),
        .seed_value     (seed_value),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .s_axis_tdata   (s_axis_tdata),
        .s_axis_tuser   (s_axis_tuser),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata),
        .mismatch_count (mismatch_count),
        .pending_draws  (pending_draws),
        .checked_draws  (checked_draws)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // tdata: low_bound, high_bound, probability, count, entry_index, entry_value
    // tuser: mode
    task automatic issue_request(input mode_t mode, input logic [31:0] lo,
                                 input logic [31:0] hi, input logic [16:0] prob,
                                 input logic [4:0] cnt, input logic [3:0] slot,
                                 input logic [31:0] val);
        int unsigned gap;
        gap = sender_steady ? 0 : $urandom_range(0, 5);
        if (gap != 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= mode;
        s_axis_tdata  <= {6'd0, val, slot, cnt, prob, hi, lo};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        requests_sent++;
    endtask

    function automatic logic [31:0] rand_bound();
        case ($urandom_range(0, 3))
            0: return $urandom();
            1: return 32'($urandom_range(0, 32'h0020_0000)) - 32'h0010_0000;
            2:
            begin
                case ($urandom_range(0, 3))
                    0: return 32'h8000_0000;
                    1: return 32'h7fff_ffff;
                    2: return 32'hffff_ffff;
                    default: return 32'd0;
                endcase
            end
            default: return $urandom() >> $urandom_range(0, 31);
        endcase
    endfunction

    task automatic send_random_request();
        int unsigned roll;
        mode_t       mode;
        logic [16:0] prob;
        logic [4:0]  cnt;
        roll = $urandom_range(0, 99);
        mode = (roll < 30) ? MODE_RANGE :
               (roll < 55) ? MODE_BOOL  :
               (roll < 85) ? MODE_CHOICE : MODE_LOAD;
        prob = ($urandom_range(0, 4) == 0) ? 17'($urandom_range(0, 131071))
                                           : 17'($urandom_range(0, 65536));
        cnt  = ($urandom_range(0, 5) == 0) ? 5'($urandom_range(17, 31))
                                           : 5'($urandom_range(0, 16));
        issue_request(mode, rand_bound(), rand_bound(), prob, cnt,
                      4'($urandom_range(0, 15)), $urandom());
    endtask

    // lower valid in the step of the last handshake, then let every draw come back
    task automatic drain_requests();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_draws != 0)
            @(posedge clk);
        // a trailing table load may still be in the pipe
        repeat (4) @(posedge clk);
    endtask

    task automatic program_seed(input logic [31:0] seed);
        drain_requests();
        seed_wr_en <= 1'b1;
        seed_value <= seed;
        @(posedge clk);
        seed_wr_en <= 1'b0;
        seeds_written++;
    endtask

    // receiver: random stalls per result, plus a long hold-off on request
    initial
    begin
        int unsigned stall;
        int unsigned holdoffs_served;
        holdoffs_served = 0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (holdoff_asks != holdoffs_served)
            begin
                holdoffs_served = holdoff_asks;
                m_axis_tready <= 1'b0;
                repeat (HOLDOFF_CYCLES) @(posedge clk);
            end
            stall = recv_steady ? 0 : $urandom_range(0, 5);
            if (stall != 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge clk);
            while (!m_axis_tvalid)
                @(posedge clk);
        end
    end

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part, from the reset seed
        issue_request(MODE_LOAD, 32'd0, 32'd0, 17'd0, 5'd0, 4'd0, 32'h7fff_ffff);
        issue_request(MODE_LOAD, 32'd0, 32'd0, 17'd0, 5'd0, 4'd15, 32'h8000_0000);
        issue_request(MODE_LOAD, 32'hffff_ffff, 32'hffff_ffff, 17'h1ffff, 5'h1f, 4'd7,
                      32'h0001_0000);
        issue_request(MODE_RANGE, 32'h8000_0000, 32'h7fff_ffff, 17'd0, 5'd0, 4'd0, 32'd0);
        issue_request(MODE_RANGE, 32'h7fff_ffff, 32'h8000_0000, 17'd0, 5'd0, 4'd0, 32'd0);
        issue_request(MODE_RANGE, 32'h1234_5678, 32'h1234_5678, 17'd0, 5'd0, 4'd0, 32'd0);
        issue_request(MODE_RANGE, 32'd0, 32'h0001_0000, 17'd0, 5'd0, 4'd0, 32'd0);
        issue_request(MODE_RANGE, 32'h0001_0000, 32'hffff_0000, 17'd0, 5'd0, 4'd0, 32'd0);
        issue_request(MODE_RANGE, 32'hffff_ffff, 32'd0, 17'h1ffff, 5'h1f, 4'hf,
                      32'hffff_ffff);
        issue_request(MODE_BOOL, 32'd0, 32'd0, 17'd0, 5'd0, 4'd0, 32'd0);
        issue_request(MODE_BOOL, 32'd0, 32'd0, 17'd65536, 5'd0, 4'd0, 32'd0);
        issue_request(MODE_BOOL, 32'd0, 32'd0, 17'd65537, 5'd0, 4'd0, 32'd0);
        issue_request(MODE_BOOL, 32'd0, 32'd0, 17'h1ffff, 5'd0, 4'd0, 32'd0);
        issue_request(MODE_BOOL, 32'd0, 32'd0, 17'd32768, 5'd0, 4'd0, 32'd0);
        issue_request(MODE_CHOICE, 32'd0, 32'd0, 17'd0, 5'd0, 4'd0, 32'd0);
        issue_request(MODE_CHOICE, 32'd0, 32'd0, 17'd0, 5'd1, 4'd0, 32'd0);
        issue_request(MODE_CHOICE, 32'd0, 32'd0, 17'd0, 5'd8, 4'd0, 32'd0);
        issue_request(MODE_CHOICE, 32'd0, 32'd0, 17'd0, 5'd16, 4'd0, 32'd0);
        issue_request(MODE_CHOICE, 32'd0, 32'd0, 17'd0, 5'd17, 4'd0, 32'd0);
        issue_request(MODE_CHOICE, 32'd0, 32'd0, 17'd0, 5'h1f, 4'd0, 32'd0);
        issue_request(MODE_LOAD, 32'd0, 32'd0, 17'd0, 5'd0, 4'd15, 32'd0);
        issue_request(MODE_CHOICE, 32'hffff_ffff, 32'hffff_ffff, 17'h1ffff, 5'd16, 4'hf,
                      32'hffff_ffff);

        // zero seed falls back to the default; long output hold-off mid-stream
        program_seed(32'd0);
        repeat (50) send_random_request();
        holdoff_asks <= holdoff_asks + 1;
        repeat (200) send_random_request();

        // back-to-back on both sides
        program_seed(32'hffff_ffff);
        sender_steady = 1'b1;
        recv_steady  <= 1'b1;
        repeat (250) send_random_request();
        sender_steady = 1'b0;
        recv_steady  <= 1'b0;

        program_seed($urandom());
        repeat (120) send_random_request();
        drain_requests();
        repeat (130) send_random_request();

        program_seed(32'd1);
        sender_steady = 1'b1;
        repeat (250) send_random_request();
        sender_steady = 1'b0;

        program_seed(32'h8000_0000);
        recv_steady <= 1'b1;
        repeat (120) send_random_request();
        recv_steady <= 1'b0;
        repeat (130) send_random_request();

        drain_requests();
        repeat (8) @(posedge clk);
        $display("ran %0d requests under %0d seed writes, %0d draws checked, %0d mismatches",
                 requests_sent, seeds_written, checked_draws, mismatch_count);
        if (mismatch_count == 0)
            $display("[xorshift128_random_ranger] OK");
        else
            $display("[xorshift128_random_ranger] ERROR");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("timeout with %0d draws outstanding", pending_draws);
        $display("[xorshift128_random_ranger] ERROR");
        $finish;
    end

endmodule
